// File: rtl/b64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet mapping for the Base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  localparam logic [7:0] PadChar = 8'h3d;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] sextet_t;
  typedef byte_t [MaxRes-1:0] res_arr_t;
  typedef logic [CntW-1:0] res_cnt_t;

  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } mode_e;

  function automatic byte_t enc_char(sextet_t v);
    byte_t r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      r = 8'h2b;
    end else begin
      r = 8'h2f;
    end
    return r;
  endfunction

  function automatic sextet_t sextet_of(byte_t c);
    byte_t r;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = c - 8'h30 + 8'd52;
    end else if (c == 8'h2b) begin
      r = 8'd62;
    end else if (c == 8'h2f) begin
      r = 8'd63;
    end else begin
      r = 8'd0;
    end
    return r[5:0];
  endfunction

endpackage

// File: rtl/base64_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec
// Streaming Base64 encoder or decoder, standard alphabet, selected by mode.
// ----------------------------------------------------------------------------
// Each accepted item is converted into a burst of up to four results, held
// in a result register and shifted out one per cycle while the output is not
// stalled. The next item is taken once the burst is down to its final result
// as that one leaves. Encoding gives four characters per three bytes (up to
// four on the last byte); decoding gives up to three bytes on the closing
// character of a group, and the next character waits while they leave. The
// single result port sets the rate.
// A write on the configuration channel selects the mode and starts a new
// stream; the write is always ready.
module base64_codec
  import b64_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  mode_e        mode_q;
  logic [1:0]   phase_q, phase_d;
  logic [17:0]  held_q, held_d;
  logic         pad_q, pad_d;

  res_arr_t     res_q, res_d;
  res_cnt_t     cnt_q, cnt_d;
  logic         rlast_q, rlast_d;

  res_arr_t     new_res;
  res_cnt_t     new_cnt;

  logic         accept, take, cfg_wr;

  logic [23:0]  acc, word;
  logic [2:0]   gcnt;
  logic         third_pad, fourth_pad;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = res_q[0];
  assign out_last_o  = rlast_q && (cnt_q == res_cnt_t'(1));
  assign take        = out_valid_o && !out_stall_i;
  assign in_stall_o  = !((cnt_q == '0) || ((cnt_q == res_cnt_t'(1)) && take));
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    new_res    = '0;
    new_cnt    = '0;
    phase_d    = phase_q;
    held_d     = held_q;
    pad_d      = pad_q;
    acc        = {held_q, sextet_of(in_byte_i)};
    gcnt       = {1'b0, phase_q} + 3'd1;
    word       = acc;
    third_pad  = 1'b1;
    fourth_pad = 1'b1;
    if (mode_q == ModeEncode) begin
      unique case (phase_q)
        2'd0: begin
          new_res[0] = enc_char(in_byte_i[7:2]);
          held_d     = {16'd0, in_byte_i[1:0]};
          phase_d    = 2'd1;
          new_cnt    = res_cnt_t'(1);
          if (in_last_i) begin
            new_res[1] = enc_char({in_byte_i[1:0], 4'd0});
            new_res[2] = PadChar;
            new_res[3] = PadChar;
            new_cnt    = res_cnt_t'(4);
          end
        end
        2'd1: begin
          new_res[0] = enc_char({held_q[1:0], in_byte_i[7:4]});
          held_d     = {14'd0, in_byte_i[3:0]};
          phase_d    = 2'd2;
          new_cnt    = res_cnt_t'(1);
          if (in_last_i) begin
            new_res[1] = enc_char({in_byte_i[3:0], 2'd0});
            new_res[2] = PadChar;
            new_cnt    = res_cnt_t'(3);
          end
        end
        default: begin
          new_res[0] = enc_char({held_q[3:0], in_byte_i[7:6]});
          new_res[1] = enc_char(in_byte_i[5:0]);
          held_d     = '0;
          phase_d    = 2'd0;
          new_cnt    = res_cnt_t'(2);
        end
      endcase
    end else begin
      if (phase_q == 2'd2) begin
        pad_d = (in_byte_i == PadChar);
      end
      if (gcnt < 3'd4 && !in_last_i) begin
        held_d  = acc[17:0];
        phase_d = gcnt[1:0];
      end else begin
        unique case (gcnt)
          3'd1:    word = acc << 18;
          3'd2:    word = acc << 12;
          3'd3:    word = acc << 6;
          default: word = acc;
        endcase
        third_pad  = (gcnt >= 3'd3) ? pad_d : 1'b1;
        fourth_pad = (gcnt == 3'd4) ? (in_byte_i == PadChar) : 1'b1;
        new_res[0] = word[23:16];
        new_cnt    = res_cnt_t'(1);
        if (!third_pad) begin
          new_res[1] = word[15:8];
          new_cnt    = res_cnt_t'(2);
        end
        if (!fourth_pad) begin
          new_res[new_cnt[1:0]] = word[7:0];
          new_cnt               = new_cnt + res_cnt_t'(1);
        end
        phase_d = '0;
        held_d  = '0;
        pad_d   = 1'b0;
      end
    end
    if (in_last_i) begin
      phase_d = '0;
      held_d  = '0;
      pad_d   = 1'b0;
    end
  end

  always_comb begin
    res_d   = res_q;
    cnt_d   = cnt_q;
    rlast_d = rlast_q;
    if (accept) begin
      res_d   = new_res;
      cnt_d   = new_cnt;
      rlast_d = in_last_i;
    end else if (take) begin
      res_d   = {8'd0, res_q[MaxRes-1:1]};
      cnt_d   = cnt_q - res_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeEncode;
      phase_q <= '0;
      held_q  <= '0;
      pad_q   <= 1'b0;
      cnt_q   <= '0;
      rlast_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      rlast_q <= rlast_d;
      if (cfg_wr) begin
        mode_q  <= mode_e'(cfg_data_i);
        phase_q <= '0;
        held_q  <= '0;
        pad_q   <= 1'b0;
      end else if (accept) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        pad_q   <= pad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

// File: tb/base64_codec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec_checker
// Watches the configuration, input and output channels of the Base64 codec.
// It predicts every character or byte that an accepted item should produce,
// queues the predictions in order and compares each accepted output item
// field by field against the oldest one.
// ----------------------------------------------------------------------------
module base64_codec_checker
  import b64_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         errors_o,
  output int         pending_o,
  output int         checked_o
);

  localparam logic [0:63][7:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } coded_t;

  mode_e       mode_q;
  logic [1:0]  phase_q;
  logic [17:0] held_q;
  logic        pad_q;
  coded_t      due_q[$];
  int          err_n;
  int          seen_n;

  function automatic logic [5:0] sextet_for(logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (Alphabet[i] == c) return 6'(i);
    end
    return 6'd0;
  endfunction

  task automatic clear_group();
    phase_q = 2'd0;
    held_q  = 18'd0;
    pad_q   = 1'b0;
  endtask

  task automatic code_item(input logic [7:0] b, input logic last);
    logic [7:0]  res [4];
    int          n;
    int          cnt;
    logic [23:0] acc;
    logic [31:0] word;
    logic        third_pad;
    logic        fourth_pad;
    coded_t      item;
    n = 0;
    if (mode_q == ModeEncode) begin
      case (phase_q)
        2'd0: begin
          res[0]  = Alphabet[b[7:2]];
          n       = 1;
          held_q  = {16'd0, b[1:0]};
          phase_q = 2'd1;
          if (last) begin
            res[1] = Alphabet[{b[1:0], 4'b0000}];
            res[2] = PadChar;
            res[3] = PadChar;
            n      = 4;
          end
        end
        2'd1: begin
          res[0]  = Alphabet[{held_q[1:0], b[7:4]}];
          n       = 1;
          held_q  = {14'd0, b[3:0]};
          phase_q = 2'd2;
          if (last) begin
            res[1] = Alphabet[{b[3:0], 2'b00}];
            res[2] = PadChar;
            n      = 3;
          end
        end
        default: begin
          res[0]  = Alphabet[{held_q[3:0], b[7:6]}];
          res[1]  = Alphabet[b[5:0]];
          n       = 2;
          held_q  = 18'd0;
          phase_q = 2'd0;
        end
      endcase
    end else begin
      acc = {held_q, sextet_for(b)};
      cnt = int'(phase_q) + 1;
      if (phase_q == 2'd2) pad_q = (b == PadChar);
      if (cnt < 4 && !last) begin
        held_q  = acc[17:0];
        phase_q = 2'(cnt);
      end else begin
        third_pad  = (cnt >= 3) ? pad_q : 1'b1;
        fourth_pad = (cnt == 4) ? (b == PadChar) : 1'b1;
        word = {8'd0, acc} << (6 * (4 - cnt));
        res[0] = word[23:16];
        n      = 1;
        if (!third_pad) begin
          res[n] = word[15:8];
          n      = n + 1;
        end
        if (!fourth_pad) begin
          res[n] = word[7:0];
          n      = n + 1;
        end
        clear_group();
      end
    end
    if (last) clear_group();
    for (int k = 0; k < n; k++) begin
      item.data = res[k];
      item.last = last && (k == n - 1);
      due_q.push_back(item);
    end
  endtask

  task automatic check_result();
    coded_t want;
    if (due_q.size() == 0) begin
      err_n++;
      $error("unexpected output item: out_byte %h out_last %b", out_byte_i, out_last_i);
    end else begin
      want = due_q.pop_front();
      seen_n++;
      if (out_byte_i !== want.data) begin
        err_n++;
        $error("out_byte: expected %h, got %h", want.data, out_byte_i);
      end
      if (out_last_i !== want.last) begin
        err_n++;
        $error("out_last: expected %b, got %b", want.last, out_last_i);
      end
    end
  endtask

  // Drain the output first: an item accepted at this edge cannot answer itself.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = ModeEncode;
      clear_group();
      due_q.delete();
      err_n  = 0;
      seen_n = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q = mode_e'(cfg_data_i);
        clear_group();
      end
      if (in_valid_i && !in_stall_i) code_item(in_byte_i, in_last_i);
    end
    errors_o  <= err_n;
    pending_o <= due_q.size();
    checked_o <= seen_n;
  end

endmodule

// File: tb/tb_base64_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_codec
// Drives the Base64 codec with directed and random encode and decode streams
// under changing idle and stall patterns, one long output hold-off included,
// and gives the verdict from the checker's error and outstanding counts.
// ----------------------------------------------------------------------------
module tb_base64_codec;
  import b64_pkg::*;

  localparam int HoldCycles = 300;
  localparam int QuietLimit = 4000;
  localparam int PhaseItems = 26;
  localparam int Phases     = 8;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_data_i  = 1'b0;
  logic       cfg_ready_o;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'd0;
  logic       in_last_i   = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  int errors;
  int pending;
  int checked;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left  = 0;
  int quiet      = 0;
  int items_sent = 0;

  base64_codec dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  base64_codec_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_i  (out_byte_o),
    .out_last_i  (out_last_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hold the output for a long stretch on request, else stall at random.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
      hold_taken  <= hold_asked;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QuietLimit) begin
      $display("base64_codec: mismatch");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_str(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], last && (i == s.len() - 1));
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input mode_e m);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 8'h41 + 8'($urandom_range(0, 25));
      3, 4, 5: c = 8'h61 + 8'($urandom_range(0, 25));
      6, 7:    c = 8'h30 + 8'($urandom_range(0, 9));
      8:       c = $urandom_range(0, 1) ? 8'h2b : 8'h2f;
      default: c = ($urandom_range(0, 3) == 0) ? PadChar : 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  task automatic encode_stream();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) send_item(8'($urandom_range(0, 255)), i == n - 1);
  endtask

  // Random lengths with random content; deliberate padding only on a full final group.
  task automatic decode_stream();
    int n;
    int pads;
    n    = $urandom_range(1, 12);
    pads = (n % 4 == 0) ? $urandom_range(0, 2) : 0;
    for (int i = 0; i < n; i++) begin
      send_item((i >= n - pads) ? PadChar : pick_char(),
                (i == n - 1) && ($urandom_range(0, 9) != 0));
    end
  endtask

  initial begin
    mode_e m;
    int    sent0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(ModeEncode);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h4d, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h6e, 1'b0);
    send_item(8'hfc, 1'b1);
    in_valid_i <= 1'b0;
    drain();

    write_mode(ModeDecode);
    send_str("A/z9", 1'b0);
    send_str("QUI=", 1'b0);
    send_item(8'h2b, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(PadChar, 1'b0);
    send_item(8'hff, 1'b0);
    send_str("Q", 1'b1);
    send_str("QQ=", 1'b1);
    send_str("QUJ", 1'b1);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < Phases; p++) begin
      m = (p % 2 == 1) ? ModeDecode : ModeEncode;
      case (p / 2)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 75; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 75; end
        default: begin idle_pct = 36; stall_pct <= 36; end
      endcase
      write_mode(m);
      if (p == 0) hold_asked <= hold_asked + 1;
      sent0 = items_sent;
      while (items_sent - sent0 < PhaseItems) begin
        if (m == ModeEncode) encode_stream();
        else decode_stream();
      end
      in_valid_i <= 1'b0;
      drain();
    end

    repeat (16) @(posedge clk_i);
    $display("Run covered %0d items in both modes over %0d idle and stall phases,",
             items_sent, Phases + 2);
    $display("with a %0d-cycle output hold-off; %0d output items checked.",
             HoldCycles, checked);
    if (errors == 0 && pending == 0) begin
      $display("base64_codec: match");
    end else begin
      $display("base64_codec: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/b64_pkg.sv
rtl/base64_codec.sv
tb/base64_codec_checker.sv
tb/tb_base64_codec.sv
